// ===== hw/rtl/bfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsp_pkg
// shared types and constants of the fewest-hop path finder
// ----------------------------------------------------------------------------
package bfsp_pkg;

    // default sizing of the graph
    localparam int VERTEX_COUNT_DEF = 16;
    localparam int WEIGHT_BITS_DEF  = 8;

    // fixed widths of the word fields
    localparam int VERTEX_W = 4;
    localparam int DIST_W   = 12;

    typedef logic [VERTEX_W-1:0] t_vertex;
    typedef logic [DIST_W-1:0]   t_dist;

    localparam t_dist DIST_MAX = {DIST_W{1'b1}};

    // action codes of an input word
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // one result word from the search engine to the output register
    typedef struct packed {
        t_vertex vertex;
        logic    found;
        t_dist   distance;
        logic    last;
    } t_result;

endpackage

// ===== hw/rtl/bfsp_wram.sv =====
// ----------------------------------------------------------------------------
// bfsp_wram
// edge weight memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module bfsp_wram #(
    parameter int DEPTH = bfsp_pkg::VERTEX_COUNT_DEF * bfsp_pkg::VERTEX_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = bfsp_pkg::WEIGHT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bfsp_engine.sv =====
// ----------------------------------------------------------------------------
// bfsp_engine
// clearing sweep, breadth-first search, parent walk and path emission
// ----------------------------------------------------------------------------
module bfsp_engine #(
    parameter int VERTEX_COUNT = bfsp_pkg::VERTEX_COUNT_DEF,
    parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF,
    parameter int AW           = $clog2(VERTEX_COUNT * VERTEX_COUNT)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input word
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_action,
    input  bfsp_pkg::t_vertex      i_from_vertex,
    input  bfsp_pkg::t_vertex      i_to_vertex,
    input  logic [7:0]             i_weight,
    // weight memory
    output logic                   o_wr_we,
    output logic [AW-1:0]          o_wr_waddr,
    output logic [WEIGHT_BITS-1:0] o_wr_wdata,
    output logic [AW-1:0]          o_wr_raddr,
    input  logic [WEIGHT_BITS-1:0] i_wr_rdata,
    // result word
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output bfsp_pkg::t_result      o_res
);

    localparam int VW  = $clog2(VERTEX_COUNT);
    localparam int CW  = VW + 1;
    localparam int SAW = VW + 1;
    localparam int SW  = ((WEIGHT_BITS > bfsp_pkg::DIST_W) ? WEIGHT_BITS
                                                           : bfsp_pkg::DIST_W) + 1;

    localparam logic [CW-1:0] VC_C  = CW'(VERTEX_COUNT);
    localparam logic [CW-1:0] VC_M1 = CW'(VERTEX_COUNT - 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(VERTEX_COUNT * VERTEX_COUNT - 1);

    // scratch regions: parent table low half, queue / path stack high half
    localparam logic REG_PARENT = 1'b0;
    localparam logic REG_QUEUE  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_POPW,
        S_SCAN,
        S_PUSH,
        S_WALK,
        S_WALKW,
        S_ERD,
        S_ERW,
        S_EADD,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_clr;
    logic [VW-1:0]         r_src;
    logic [VW-1:0]         r_tgt;
    bfsp_pkg::t_vertex     r_tgt_raw;
    logic [VERTEX_COUNT-1:0] r_visited;
    logic [CW-1:0]         r_head;
    logic [CW-1:0]         r_tail;
    logic                  r_done;
    logic [VW-1:0]         r_v;
    logic [CW-1:0]         r_i;
    logic [VW-1:0]         r_chk_i;
    logic                  r_chk_vld;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_sp;
    logic                  r_first;
    logic                  r_fail;
    logic [VW-1:0]         r_cur;
    logic [VW-1:0]         r_prev;
    bfsp_pkg::t_dist       r_dist;

    // scratch memory
    logic [VW-1:0]         r_scr [0:(2**SAW)-1];
    logic [VW-1:0]         r_sc_rdata;
    logic                  sc_we;
    logic [SAW-1:0]        sc_waddr;
    logic [VW-1:0]         sc_wdata;
    logic [SAW-1:0]        sc_raddr;

    logic                  in_ok;
    logic                  disc;
    logic                  walk_more;
    logic [CW-1:0]         sp_dec;
    logic [SW-1:0]         sum;
    bfsp_pkg::t_dist       dist_sat;

    function automatic logic [AW-1:0] f_waddr(input logic [VW-1:0] row,
                                              input logic [VW-1:0] col);
        return AW'(row) * AW'(VERTEX_COUNT) + AW'(col);
    endfunction

    assign in_ok = (32'(i_from_vertex) < VERTEX_COUNT) &&
                   (32'(i_to_vertex) < VERTEX_COUNT);
    assign disc      = r_chk_vld && !r_visited[r_chk_i] && (i_wr_rdata != '0);
    assign walk_more = (r_v != r_src) && (r_cnt < VC_M1);
    assign sp_dec    = r_sp - CW'(1);
    assign sum       = SW'(r_dist) + SW'(i_wr_rdata);
    assign dist_sat  = (sum > SW'(bfsp_pkg::DIST_MAX)) ? bfsp_pkg::DIST_MAX
                                                        : bfsp_pkg::t_dist'(sum);

    // memory port control
    always_comb begin
        o_wr_we    = 1'b0;
        o_wr_waddr = '0;
        o_wr_wdata = '0;
        o_wr_raddr = '0;
        sc_we      = 1'b0;
        sc_waddr   = '0;
        sc_wdata   = '0;
        sc_raddr   = '0;
        case (r_state)
            S_CLEAR: begin
                o_wr_we    = 1'b1;
                o_wr_waddr = r_clr;
            end
            S_IDLE: begin
                if (i_valid && in_ok && (i_action == bfsp_pkg::ACT_WRITE)) begin
                    o_wr_we    = 1'b1;
                    o_wr_waddr = f_waddr(VW'(i_from_vertex), VW'(i_to_vertex));
                    o_wr_wdata = WEIGHT_BITS'(i_weight);
                end
                if (i_valid && in_ok && (i_action == bfsp_pkg::ACT_QUERY)) begin
                    sc_we    = 1'b1;
                    sc_waddr = {REG_QUEUE, VW'(0)};
                    sc_wdata = VW'(i_from_vertex);
                end
            end
            S_POP: begin
                sc_raddr = {REG_QUEUE, r_head[VW-1:0]};
            end
            S_SCAN: begin
                o_wr_raddr = f_waddr(r_v, r_i[VW-1:0]);
                if (disc) begin
                    sc_we    = 1'b1;
                    sc_waddr = {REG_PARENT, r_chk_i};
                    sc_wdata = r_v;
                end
            end
            S_PUSH: begin
                if (r_tail < VC_C) begin
                    sc_we    = 1'b1;
                    sc_waddr = {REG_QUEUE, r_tail[VW-1:0]};
                    sc_wdata = r_chk_i;
                end
            end
            S_WALK: begin
                sc_we    = 1'b1;
                sc_waddr = {REG_QUEUE, r_cnt[VW-1:0]};
                sc_wdata = walk_more ? r_v : r_src;
                sc_raddr = {REG_PARENT, r_v};
            end
            S_ERD: begin
                sc_raddr = {REG_QUEUE, sp_dec[VW-1:0]};
            end
            S_ERW: begin
                o_wr_raddr = f_waddr(r_prev, r_sc_rdata);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            r_scr[sc_waddr] <= sc_wdata;
        end
        r_sc_rdata <= r_scr[sc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_visited <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_done    <= 1'b0;
            r_chk_vld <= 1'b0;
            r_fail    <= 1'b0;
            r_first   <= 1'b0;
            r_sp      <= '0;
            r_cnt     <= '0;
            r_i       <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && (i_action == bfsp_pkg::ACT_QUERY)) begin
                        r_src     <= VW'(i_from_vertex);
                        r_tgt     <= VW'(i_to_vertex);
                        r_tgt_raw <= i_to_vertex;
                        if (in_ok) begin
                            r_fail    <= 1'b0;
                            r_visited <= VERTEX_COUNT'(1) << VW'(i_from_vertex);
                            r_head    <= '0;
                            r_tail    <= CW'(1);
                            r_done    <= 1'b0;
                            r_state   <= S_POP;
                        end else begin
                            r_fail  <= 1'b1;
                            r_sp    <= '0;
                            r_dist  <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_POP: begin
                    if (r_head < r_tail) begin
                        r_head  <= r_head + CW'(1);
                        r_state <= S_POPW;
                    end else if (r_visited[r_tgt]) begin
                        // source is the target
                        r_v     <= r_tgt;
                        r_cnt   <= '0;
                        r_state <= S_WALK;
                    end else begin
                        r_fail  <= 1'b1;
                        r_sp    <= '0;
                        r_dist  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_POPW: begin
                    r_v       <= r_sc_rdata;
                    r_i       <= '0;
                    r_chk_vld <= 1'b0;
                    r_state   <= S_SCAN;
                end
                S_SCAN: begin
                    if (disc) begin
                        r_visited[r_chk_i] <= 1'b1;
                        if (r_chk_i == r_tgt) begin
                            r_done <= 1'b1;
                        end
                        // drop the read in flight, rescan after the push
                        r_i       <= {1'b0, r_chk_i} + CW'(1);
                        r_chk_vld <= 1'b0;
                        r_state   <= S_PUSH;
                    end else if (r_i < VC_C) begin
                        r_chk_i   <= r_i[VW-1:0];
                        r_chk_vld <= 1'b1;
                        r_i       <= r_i + CW'(1);
                    end else begin
                        r_chk_vld <= 1'b0;
                        if (!r_chk_vld) begin
                            r_state <= S_POP;
                        end
                    end
                end
                S_PUSH: begin
                    if (r_tail < VC_C) begin
                        r_tail <= r_tail + CW'(1);
                    end
                    if (r_done) begin
                        r_v     <= r_tgt;
                        r_cnt   <= '0;
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_WALK: begin
                    if (walk_more) begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_WALKW;
                    end else begin
                        r_sp    <= r_cnt + CW'(1);
                        r_first <= 1'b1;
                        r_dist  <= '0;
                        r_state <= S_ERD;
                    end
                end
                S_WALKW: begin
                    r_v     <= r_sc_rdata;
                    r_state <= S_WALK;
                end
                S_ERD: begin
                    r_sp    <= sp_dec;
                    r_state <= S_ERW;
                end
                S_ERW: begin
                    r_cur <= r_sc_rdata;
                    if (r_first) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_EADD;
                    end
                end
                S_EADD: begin
                    r_dist  <= dist_sat;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_prev  <= r_cur;
                        r_first <= 1'b0;
                        if (r_sp == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ERD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_res_valid      = (r_state == S_OUT);
    assign o_res.vertex     = r_fail ? r_tgt_raw : bfsp_pkg::t_vertex'(r_cur);
    assign o_res.found      = !r_fail;
    assign o_res.distance   = r_fail ? '0 : r_dist;
    assign o_res.last       = (r_sp == '0);

endmodule

// ===== hw/rtl/bfs_fewest_hop_path.sv =====
// ----------------------------------------------------------------------------
// bfs_fewest_hop_path
// fewest-hop path finder over a weighted directed graph held in memory
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall, a word is taken when i_valid is high
//   and o_stall is low. action write stores one edge weight (0 = no edge);
//   action query searches from i_from_vertex to i_to_vertex
// output channel: o_valid / i_stall, one word per path vertex from source
//   to target with the running weight sum, o_last on the final word; an
//   unreachable target or an out-of-range vertex gives one word, found low
// after reset the weight memory is swept to zero, one entry a cycle, and
//   o_stall stays high until the sweep is done
// a query pops each queued vertex and scans its row of the weight matrix,
//   one entry per cycle except while a newly found vertex is pushed, and
//   ends when the target is found or the queue runs empty; then the parent
//   walk builds the path and the engine emits one result word per vertex
// the block works on one query at a time; a finished word waits in the
//   output register while the engine goes on, and a stalled receiver
//   holds the engine in its emit step without losing or repeating words
// ----------------------------------------------------------------------------
module bfs_fewest_hop_path #(
    parameter int VERTEX_COUNT = bfsp_pkg::VERTEX_COUNT_DEF,
    parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input words
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  bfsp_pkg::t_vertex i_from_vertex,
    input  bfsp_pkg::t_vertex i_to_vertex,
    input  logic [7:0]        i_weight,
    // result words
    output logic              o_valid,
    input  logic              i_stall,
    output bfsp_pkg::t_vertex o_vertex,
    output logic              o_found,
    output bfsp_pkg::t_dist   o_distance,
    output logic              o_last
);

    localparam int DEPTH = VERTEX_COUNT * VERTEX_COUNT;
    localparam int AW    = $clog2(DEPTH);

    // engine to weight memory
    logic                   wr_we;
    logic [AW-1:0]          wr_waddr;
    logic [WEIGHT_BITS-1:0] wr_wdata;
    logic [AW-1:0]          wr_raddr;
    logic [WEIGHT_BITS-1:0] wr_rdata;

    // engine to output register
    logic                   res_valid;
    logic                   res_ready;
    bfsp_pkg::t_result      res;

    // output register
    logic                   r_out_vld;
    bfsp_pkg::t_result      r_out;

    bfsp_wram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (WEIGHT_BITS)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (wr_we),
        .i_waddr (wr_waddr),
        .i_wdata (wr_wdata),
        .i_raddr (wr_raddr),
        .o_rdata (wr_rdata)
    );

    bfsp_engine #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .AW           (AW)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_from_vertex (i_from_vertex),
        .i_to_vertex   (i_to_vertex),
        .i_weight      (i_weight),
        .o_wr_we       (wr_we),
        .o_wr_waddr    (wr_waddr),
        .o_wr_wdata    (wr_wdata),
        .o_wr_raddr    (wr_raddr),
        .i_wr_rdata    (wr_rdata),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    // the register takes a new word when empty or being drained
    assign res_ready = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_out_vld <= 1'b1;
                r_out     <= res;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_vld;
    assign o_vertex   = r_out.vertex;
    assign o_found    = r_out.found;
    assign o_distance = r_out.distance;
    assign o_last     = r_out.last;

`ifndef NO_ASSERTIONS
    // a failure answer is always a single final word
    a_fail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> o_last)
        else $error("failure word without last");

    // a failure answer carries no distance
    a_fail_no_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_distance == '0))
        else $error("failure word with nonzero distance");

    // no input word is taken while the engine is emitting
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> o_stall)
        else $error("input taken while a result is pending");
`endif

endmodule
